// ----- rtl/core/rde_pkg.sv -----
package rde_pkg;

  localparam int unsigned RADIX_W     = 6;
  localparam int unsigned MAG_W       = 31;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned DIVIDEND_W  = 32;
  localparam int unsigned DIV_BITS    = 8;
  localparam int unsigned DIV_STEPS   = DIVIDEND_W / DIV_BITS;
  localparam int unsigned MIN_RADIX   = 2;
  localparam int unsigned MAX_RADIX   = 36;
  localparam int unsigned DEC_DIGITS  = 10;

  localparam logic [CHAR_W-1:0] MINUS_CODE = 7'h2D;
  localparam logic [CHAR_W-1:0] ZERO_CODE  = 7'h30;
  localparam logic [CHAR_W-1:0] ALPHA_CODE = 7'h41;
  localparam logic [CHAR_W-1:0] ERROR_CODE = 7'h00;

  typedef struct packed {
    logic start;
    logic div_step;
    logic emit_err;
    logic emit_zero;
    logic emit_sign;
    logic fetch;
    logic emit_digit;
  } rde_cmd_t;

  typedef struct packed {
    logic radix_bad;
    logic in_zero;
    logic div_last;
    logic quot_zero;
    logic neg;
    logic out_last;
  } rde_status_t;

  function automatic logic [CHAR_W-1:0] rde_glyph(input logic [RADIX_W-1:0] d);
    logic [RADIX_W-1:0] v;
    v = (d >= RADIX_W'(MAX_RADIX)) ? d - RADIX_W'(MAX_RADIX) : d;
    if (v < RADIX_W'(DEC_DIGITS)) begin
      return ZERO_CODE + CHAR_W'(v);
    end
    return ALPHA_CODE + CHAR_W'(v - RADIX_W'(DEC_DIGITS));
  endfunction

endpackage

// ----- rtl/core/rde_if.sv -----
interface rde_in_if;
  logic        valid;
  logic        ready;
  logic [30:0] magnitude;
  logic        negative;

  modport source (output valid, output magnitude, output negative, input ready);
  modport sink (input valid, input magnitude, input negative, output ready);
endinterface

interface rde_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last_char;
  logic       bad_radix;

  modport source (output valid, output char_code, output last_char, output bad_radix,
                  input ready);
  modport sink (input valid, input char_code, input last_char, input bad_radix,
                output ready);
endinterface

// ----- rtl/core/rde_ctrl.sv -----
module rde_ctrl
  import rde_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  rde_status_t status,
  output rde_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVIDE,
    S_FETCH,
    S_LOAD,
    S_SEND
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          if (status.radix_bad) begin
            cmd.emit_err = 1'b1;
            state_next   = S_SEND;
          end else if (status.in_zero) begin
            cmd.emit_zero = 1'b1;
            state_next    = S_SEND;
          end else begin
            state_next = S_DIVIDE;
          end
        end
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last && status.quot_zero) begin
          if (status.neg) begin
            cmd.emit_sign = 1'b1;
            state_next    = S_SEND;
          end else begin
            state_next = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.emit_digit = 1'b1;
        state_next     = S_SEND;
      end
      S_SEND: begin
        if (out_ready) begin
          state_next = status.out_last ? S_IDLE : S_FETCH;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_SEND);

endmodule

// ----- rtl/core/rde_datapath.sv -----
module rde_datapath
  import rde_pkg::*;
#(
  parameter int unsigned DIGIT_BUFFER_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [RADIX_W-1:0]  cfg_data,
  input  logic [MAG_W-1:0]    in_magnitude,
  input  logic                in_negative,
  input  rde_cmd_t            cmd,
  output rde_status_t         status,
  output logic [CHAR_W-1:0]   out_code,
  output logic                out_last,
  output logic                out_bad
);

  localparam int unsigned AW = $clog2(DIGIT_BUFFER_DEPTH);
  localparam int unsigned CW = $clog2(DIGIT_BUFFER_DEPTH + 1);
  localparam int unsigned SW = $clog2(DIV_STEPS);

  logic [RADIX_W-1:0]    radix;
  logic [DIVIDEND_W-1:0] quot;
  logic [RADIX_W-1:0]    rem;
  logic                  neg;
  logic [SW-1:0]         step;
  logic [CW-1:0]         count;
  logic [RADIX_W-1:0]    rd_data;
  logic [RADIX_W-1:0]    digit_mem [DIGIT_BUFFER_DEPTH];

  logic [DIVIDEND_W-1:0] quot_next;
  logic [RADIX_W-1:0]    rem_next;
  logic                  div_last;
  logic [CW-1:0]         count_dec;

  always_comb begin
    logic [RADIX_W:0]      r2;
    logic [RADIX_W-1:0]    r;
    logic [DIVIDEND_W-1:0] q;
    logic                  ge;
    r = rem;
    q = quot;
    for (int i = 0; i < DIV_BITS; i++) begin
      r2 = {r, q[DIVIDEND_W-1]};
      ge = (r2 >= {1'b0, radix});
      q  = {q[DIVIDEND_W-2:0], ge};
      r  = ge ? RADIX_W'(r2 - {1'b0, radix}) : r2[RADIX_W-1:0];
    end
    quot_next = q;
    rem_next  = r;
  end

  assign div_last  = (step == SW'(DIV_STEPS - 1));
  assign count_dec = count - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_W'(10);
    end else if (cfg_we) begin
      radix <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= '0;
      count <= '0;
    end else if (cmd.start) begin
      step  <= '0;
      count <= '0;
    end else if (cmd.div_step) begin
      step <= step + SW'(1);
      if (div_last && count < CW'(DIGIT_BUFFER_DEPTH)) begin
        count <= count + CW'(1);
      end
    end else if (cmd.fetch) begin
      count <= count_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      quot <= {1'b0, in_magnitude};
      rem  <= '0;
      neg  <= in_negative;
    end else if (cmd.div_step) begin
      quot <= quot_next;
      rem  <= div_last ? '0 : rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_step && div_last && count < CW'(DIGIT_BUFFER_DEPTH)) begin
      digit_mem[count[AW-1:0]] <= rem_next;
    end
    if (cmd.fetch) begin
      rd_data <= digit_mem[count_dec[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      out_code <= ERROR_CODE;
      out_last <= 1'b1;
      out_bad  <= 1'b1;
    end else if (cmd.emit_zero) begin
      out_code <= ZERO_CODE;
      out_last <= 1'b1;
      out_bad  <= 1'b0;
    end else if (cmd.emit_sign) begin
      out_code <= MINUS_CODE;
      out_last <= 1'b0;
      out_bad  <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_code <= rde_glyph(rd_data);
      out_last <= (count == '0);
      out_bad  <= 1'b0;
    end
  end

  always_comb begin
    status.radix_bad = (radix < RADIX_W'(MIN_RADIX)) || (radix > RADIX_W'(MAX_RADIX));
    status.in_zero   = (in_magnitude == '0);
    status.div_last  = div_last;
    status.quot_zero = (quot_next == '0);
    status.neg       = neg;
    status.out_last  = out_last;
  end

endmodule

// ----- rtl/core/radix_digit_emitter.sv -----
// Converts a 31-bit magnitude with a sign flag into ASCII characters in the base held
// in the radix register (2 to 36, reset 10), most significant digit first, with '-'
// ahead of a negative nonzero value and last_char on the final character. Zero gives
// one '0'; a base outside 2..36 gives one result with bad_radix set and char_code 0.
// One request is converted at a time. A bad radix or a zero magnitude yields its result
// in the cycle after the request. Otherwise the digits come from the shared restoring
// divider (8 quotient bits per cycle); a '-' sign is then loaded straight into the
// output, and each digit goes through digit buffer read, output load and send, the send
// waiting until the sink is ready.
// Only the DIGIT_BUFFER_DEPTH least significant digits are kept.
module radix_digit_emitter
  import rde_pkg::*;
#(
  parameter int unsigned DIGIT_BUFFER_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [RADIX_W-1:0] cfg_data,
  rde_in_if.sink             in_ch,
  rde_out_if.source          out_ch
);

  rde_cmd_t    cmd;
  rde_status_t status;

  rde_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  rde_datapath #(
    .DIGIT_BUFFER_DEPTH (DIGIT_BUFFER_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_magnitude (in_ch.magnitude),
    .in_negative  (in_ch.negative),
    .cmd          (cmd),
    .status       (status),
    .out_code     (out_ch.char_code),
    .out_last     (out_ch.last_char),
    .out_bad      (out_ch.bad_radix)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a result is pending");

  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.bad_radix |-> out_ch.last_char)
    else $error("error result not marked last");

  a_zero_single: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready && (in_ch.magnitude == '0)
    |=> out_ch.valid && out_ch.last_char)
    else $error("zero magnitude did not give a single result");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && out_ch.last_char |=> in_ch.ready)
    else $error("not idle after final character");

endmodule

// ----- tb/tb_radix_digit_emitter.sv -----
module tb_radix_digit_emitter;
  import rde_pkg::*;

  localparam int unsigned DIGIT_DEPTH = 32;
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
  } conv_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
    logic              bad;
  } char_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [RADIX_W-1:0] cfg_data = '0;

  rde_in_if  in_if ();
  rde_out_if out_if ();

  radix_digit_emitter #(
    .DIGIT_BUFFER_DEPTH(DIGIT_DEPTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .in_ch   (in_if),
    .out_ch  (out_if)
  );

  conv_req_t          conv_requests[$];
  char_t              char_queue[$];
  conv_req_t          req_on_bus;
  logic [RADIX_W-1:0] radix_cfg = RADIX_W'(10);
  int                 req_queued = 0;
  int                 req_accepted = 0;
  int                 err_cnt = 0;
  int                 in_gap = 0;
  int                 in_burst = 0;
  int                 out_stall = 0;
  int                 out_burst = 0;
  char_t              got_char;
  char_t              want_char;

  always #4 clk = ~clk;

  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic void predict_chars(input logic [MAG_W-1:0] mag, input logic neg);
    logic [MAG_W-1:0]   rest;
    logic [RADIX_W-1:0] digs [DIGIT_DEPTH];
    logic [RADIX_W-1:0] d;
    int                 cnt;
    char_t              c;
    if (radix_cfg < MIN_RADIX || radix_cfg > MAX_RADIX) begin
      c.code = ERROR_CODE;
      c.last = 1'b1;
      c.bad  = 1'b1;
      char_queue.push_back(c);
    end else if (mag == '0) begin
      c.code = ZERO_CODE;
      c.last = 1'b1;
      c.bad  = 1'b0;
      char_queue.push_back(c);
    end else begin
      rest = mag;
      cnt  = 0;
      while (rest != '0) begin
        if (cnt < DIGIT_DEPTH) begin
          digs[cnt] = RADIX_W'(rest % radix_cfg);
          cnt++;
        end
        rest = rest / radix_cfg;
      end
      c.bad = 1'b0;
      if (neg) begin
        c.code = MINUS_CODE;
        c.last = 1'b0;
        char_queue.push_back(c);
      end
      for (int i = cnt - 1; i >= 0; i--) begin
        d = digs[i];
        if (d < RADIX_W'(DEC_DIGITS)) begin
          c.code = ZERO_CODE + CHAR_W'(d);
        end else begin
          c.code = ALPHA_CODE + CHAR_W'(d - RADIX_W'(DEC_DIGITS));
        end
        c.last = (i == 0);
        char_queue.push_back(c);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_if.valid     <= 1'b0;
      in_if.magnitude <= '0;
      in_if.negative  <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_chars(req_on_bus.mag, req_on_bus.neg);
        req_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (conv_requests.size() > 0) begin
          req_on_bus = conv_requests.pop_front();
          in_if.valid     <= 1'b1;
          in_if.magnitude <= req_on_bus.mag;
          in_if.negative  <= req_on_bus.neg;
          in_gap = pick_gap(in_burst);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got_char.code = out_if.char_code;
        got_char.last = out_if.last_char;
        got_char.bad  = out_if.bad_radix;
        if (char_queue.size() == 0) begin
          $error("unexpected character: char_code %0h last_char %0b bad_radix %0b",
                 got_char.code, got_char.last, got_char.bad);
          err_cnt++;
        end else begin
          want_char = char_queue.pop_front();
          if (got_char.code !== want_char.code) begin
            $error("char_code: expected %0h, got %0h", want_char.code, got_char.code);
            err_cnt++;
          end
          if (got_char.last !== want_char.last) begin
            $error("last_char: expected %0b, got %0b", want_char.last, got_char.last);
            err_cnt++;
          end
          if (got_char.bad !== want_char.bad) begin
            $error("bad_radix: expected %0b, got %0b", want_char.bad, got_char.bad);
            err_cnt++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_stall = pick_gap(out_burst);
        out_if.ready <= (out_stall == 0);
      end
    end
  end

  task automatic add_item(input logic [MAG_W-1:0] mag, input logic neg);
    conv_req_t r;
    r.mag = mag;
    r.neg = neg;
    conv_requests.push_back(r);
    req_queued++;
  endtask

  task automatic drain();
    while (!(req_accepted == req_queued && char_queue.size() == 0)) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_radix(input logic [RADIX_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_data  <= v;
    radix_cfg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [RADIX_W-1:0] radix_list [$];
    logic [63:0]        pw;
    logic [MAG_W-1:0]   mag;
    int                 n_items;
    int                 k;

    in_if.valid     = 1'b0;
    in_if.magnitude = '0;
    in_if.negative  = 1'b0;
    out_if.ready    = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    add_item('0, 1'b0);
    add_item('0, 1'b1);
    add_item(MAG_W'(1), 1'b0);
    add_item(MAG_W'(1), 1'b1);
    add_item(MAG_MAX, 1'b0);
    add_item(MAG_MAX, 1'b1);
    add_item(MAG_W'(9), 1'b1);
    add_item(MAG_W'(10), 1'b0);
    add_item(MAG_W'(1000000000), 1'b1);
    drain();

    program_radix(RADIX_W'(2));
    add_item(MAG_MAX, 1'b1);
    add_item(MAG_W'(1), 1'b0);
    add_item(MAG_W'(32'h5555_5555), 1'b0);
    add_item(MAG_W'(32'h2AAA_AAAA), 1'b1);
    add_item(MAG_W'(32'h4000_0000), 1'b0);
    drain();

    program_radix(RADIX_W'(MAX_RADIX));
    add_item(MAG_W'(35), 1'b0);
    add_item(MAG_W'(36), 1'b1);
    add_item(MAG_MAX, 1'b0);
    add_item(MAG_W'(36 * 36 - 1), 1'b1);
    drain();

    program_radix(RADIX_W'(0));
    add_item('0, 1'b1);
    add_item(MAG_MAX, 1'b1);
    drain();

    program_radix(RADIX_W'(37));
    add_item(MAG_W'(5), 1'b0);
    drain();

    radix_list = '{6'd2, 6'd3, 6'd7, 6'd8, 6'd10, 6'd16, 6'd35, 6'd36, 6'd1, 6'd63};
    radix_list.push_back(RADIX_W'($urandom_range(0, 63)));
    radix_list.push_back(RADIX_W'($urandom_range(0, 63)));
    radix_list.push_back(RADIX_W'($urandom_range(MIN_RADIX, MAX_RADIX)));

    foreach (radix_list[p]) begin
      program_radix(radix_list[p]);
      if (radix_cfg < MIN_RADIX || radix_cfg > MAX_RADIX) n_items = 8;
      else n_items = 27;
      repeat (n_items) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: mag = MAG_W'($urandom());
          4, 5:       mag = MAG_W'($urandom() >> $urandom_range(1, 31));
          6:          mag = MAG_W'($urandom_range(0, 40));
          7: begin
            pw = 64'd1;
            k  = $urandom_range(0, 30);
            if (radix_cfg >= MIN_RADIX) begin
              repeat (k) if (pw * radix_cfg <= MAG_MAX) pw = pw * radix_cfg;
            end
            mag = MAG_W'(pw - 64'd1 + 64'($urandom_range(0, 2)));
          end
          8:          mag = MAG_MAX - MAG_W'($urandom_range(0, 3));
          default:    mag = '0;
        endcase
        add_item(mag, 1'($urandom()));
      end
      drain();
    end

    repeat (250) @(posedge clk);
    if (char_queue.size() != 0) begin
      $error("characters still expected at end of run: %0d", char_queue.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("tb_radix_digit_emitter: clean");
    end else begin
      $display("tb_radix_digit_emitter: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #40000000;
    $display("tb_radix_digit_emitter: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/rde_pkg.sv
rtl/core/rde_if.sv
rtl/core/rde_ctrl.sv
rtl/core/rde_datapath.sv
rtl/core/radix_digit_emitter.sv
tb/tb_radix_digit_emitter.sv
